>>> rtl/core/wlsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsc_pkg
// Shared types, widths and codes for the winch limit switch controller.
// ----------------------------------------------------------------------------
package wlsc_pkg;

  localparam int NUM_WINCHES_DEF = 3;
  localparam int MAX_WINCHES     = 4;
  localparam int REPORTED        = 3;

  localparam int CMD_W     = 8;
  localparam int DRV_W     = 2;
  localparam int POS_W     = 25;
  localparam int CLK_W     = 32;
  localparam int DEB_W     = 16;
  localparam int STEP_W    = 25;
  localparam int ELAPSED_W = 10;
  localparam int DELTA_W   = ELAPSED_W + STEP_W;
  localparam int CFG_W     = 25;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  // input word layout
  localparam int IN_MASK_LSB    = 3 * CMD_W;
  localparam int IN_ELAPSED_LSB = IN_MASK_LSB + 3;

  // output word layout
  localparam int OUT_STBY_LSB   = 3 * DRV_W;
  localparam int OUT_POS_LSB    = OUT_STBY_LSB + 1;
  localparam int OUT_INEND_LSB  = OUT_POS_LSB + 3 * POS_W;
  localparam int OUT_OUTEND_LSB = OUT_INEND_LSB + 3;

  localparam logic [POS_W-1:0]  FULL_STROKE  = POS_W'(25'h100_0000);
  localparam logic [POS_W-1:0]  HALF_STROKE  = POS_W'(25'h080_0000);
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(20);
  localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(1678);

  typedef logic [DRV_W-1:0] drive_t;
  localparam drive_t DRV_OFF = 2'b00;
  localparam drive_t DRV_OUT = 2'b01;
  localparam drive_t DRV_IN  = 2'b11;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_STEP     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CLK_W-1:0]   now_ms;
    logic [DELTA_W-1:0] delta;
    logic [DEB_W-1:0]   debounce_ms;
  } shared_t;

  typedef struct packed {
    drive_t           drive;
    logic [POS_W-1:0] pos;
    logic             in_end;
    logic             out_end;
  } lane_res_t;

endpackage

>>> rtl/core/winch_limit_switch_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winch_limit_switch_control
// Debounced end stop control of NUM_WINCHES winches, the first three fed and reported, one tick per word.
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      cmd_a, cmd_b, cmd_c, limit_raw_mask, elapsed_ms
// out_     out  tvalid/tready      drives, standby, positions, end masks
// cfg_     in   we                 debounce_ms (0), travel_step (1)
//
// one word per cycle while in_tready is high; each result is registered when its word is taken
// all lanes update in the accept cycle; results leave through the output register
// a two-entry output buffer keeps in_tready high while one result waits
// reset is synchronous: positions return to half stroke, clock and stops clear
// ----------------------------------------------------------------------------
module winch_limit_switch_control #(
  parameter int NUM_WINCHES = wlsc_pkg::NUM_WINCHES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd_a, cmd_b, cmd_c, limit_raw_mask, elapsed_ms, zero fill
  input  logic [wlsc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_a, drive_b, drive_c, standby_enable, pos_a, pos_b, pos_c,
  // in_end_mask, out_end_mask
  output logic [wlsc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [wlsc_pkg::CFG_W-1:0]          cfg_wdata
);

  logic [wlsc_pkg::DEB_W-1:0]       debounce_ms_r;
  logic [wlsc_pkg::STEP_W-1:0]      travel_step_r;
  logic [wlsc_pkg::CLK_W-1:0]       clock_ms_r, clock_ms_nxt;
  logic                             out_valid_r;
  logic [wlsc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                             skid_valid_r;
  logic [wlsc_pkg::OUT_TDATA_W-1:0] skid_data_r;

  logic                             accept;
  logic [wlsc_pkg::ELAPSED_W-1:0]   elapsed;
  wlsc_pkg::shared_t                shr;
  wlsc_pkg::lane_res_t              lane_res [NUM_WINCHES];
  logic [wlsc_pkg::OUT_TDATA_W-1:0] result;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign elapsed      = in_tdata[wlsc_pkg::IN_ELAPSED_LSB +: wlsc_pkg::ELAPSED_W];
  assign clock_ms_nxt = clock_ms_r + {{(wlsc_pkg::CLK_W-wlsc_pkg::ELAPSED_W){1'b0}}, elapsed};

  assign shr.now_ms      = clock_ms_nxt;
  assign shr.delta       = {{(wlsc_pkg::DELTA_W-wlsc_pkg::ELAPSED_W){1'b0}}, elapsed}
                         * {{(wlsc_pkg::DELTA_W-wlsc_pkg::STEP_W){1'b0}}, travel_step_r};
  assign shr.debounce_ms = debounce_ms_r;

  for (genvar g = 0; g < NUM_WINCHES; g++) begin : g_lane
    logic [wlsc_pkg::CMD_W-1:0] cmd;
    logic                       raw;
    if (g < wlsc_pkg::REPORTED) begin : g_fed
      assign cmd = in_tdata[g*wlsc_pkg::CMD_W +: wlsc_pkg::CMD_W];
      assign raw = in_tdata[wlsc_pkg::IN_MASK_LSB + g];
    end else begin : g_idle
      assign cmd = '0;
      assign raw = 1'b0;
    end
    wlsc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step_en (accept),
      .shr     (shr),
      .cmd     (cmd),
      .raw     (raw),
      .res     (lane_res[g])
    );
  end

  wlsc_merge #(
    .NUM_WINCHES (NUM_WINCHES)
  ) u_merge (
    .lane_res (lane_res),
    .tdata    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= wlsc_pkg::DEBOUNCE_RST;
      travel_step_r <= wlsc_pkg::STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wlsc_pkg::CFG_DEBOUNCE: debounce_ms_r <= cfg_wdata[wlsc_pkg::DEB_W-1:0];
        wlsc_pkg::CFG_STEP:     travel_step_r <= cfg_wdata[wlsc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_ms_r <= '0;
    end else if (accept) begin
      clock_ms_r <= clock_ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= result;
      end
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("buffered word without a pending output word");

  a_standby_matches : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6] == (|out_tdata[5:0])))
    else $error("standby disagrees with drive fields");

  a_end_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[84:82] & out_tdata[87:85]) == 3'b000))
    else $error("winch reported at both ends");

  a_pos_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[31] && (|out_tdata[30:7])))
    else $error("winch 0 position beyond full stroke");
`endif

endmodule

>>> rtl/core/wlsc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsc_lane
// One winch: end stop debounce, direction blocking and position tracking.
// ----------------------------------------------------------------------------
module wlsc_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  wlsc_pkg::shared_t          shr,
  input  logic [wlsc_pkg::CMD_W-1:0] cmd,
  input  logic                       raw,
  output wlsc_pkg::lane_res_t        res
);

  logic                         raw_level_r;
  logic [wlsc_pkg::CLK_W-1:0]   change_time_r, change_time_nxt;
  logic                         pressed_r, pressed_nxt;
  wlsc_pkg::drive_t             last_dir_r, last_dir_nxt;
  wlsc_pkg::drive_t             blocked_r, blocked_nxt;
  logic [wlsc_pkg::POS_W-1:0]   pos_r, pos_nxt;

  logic [wlsc_pkg::CLK_W-1:0]   held;
  logic [wlsc_pkg::POS_W-1:0]   pos_snap;
  logic [wlsc_pkg::POS_W-1:0]   headroom;
  wlsc_pkg::drive_t             dir;

  always_comb begin
    change_time_nxt = (raw != raw_level_r) ? shr.now_ms : change_time_r;
    held            = shr.now_ms - change_time_nxt;
    pressed_nxt     = pressed_r;
    blocked_nxt     = blocked_r;
    pos_snap        = pos_r;
    if (held >= {{(wlsc_pkg::CLK_W-wlsc_pkg::DEB_W){1'b0}}, shr.debounce_ms}
        && raw != pressed_r) begin
      pressed_nxt = raw;
      if (raw) begin
        blocked_nxt = last_dir_r;
        if (last_dir_r == wlsc_pkg::DRV_IN)  pos_snap = '0;
        if (last_dir_r == wlsc_pkg::DRV_OUT) pos_snap = wlsc_pkg::FULL_STROKE;
      end else begin
        blocked_nxt = wlsc_pkg::DRV_OFF;
      end
    end

    if (cmd == '0) dir = wlsc_pkg::DRV_OFF;
    else if (cmd[wlsc_pkg::CMD_W-1]) dir = wlsc_pkg::DRV_IN;
    else dir = wlsc_pkg::DRV_OUT;
    if (dir != wlsc_pkg::DRV_OFF && pressed_nxt && dir == blocked_nxt) dir = wlsc_pkg::DRV_OFF;

    headroom     = wlsc_pkg::FULL_STROKE - pos_snap;
    last_dir_nxt = last_dir_r;
    pos_nxt      = pos_snap;
    if (dir == wlsc_pkg::DRV_OUT) begin
      last_dir_nxt = dir;
      if (shr.delta >= {{(wlsc_pkg::DELTA_W-wlsc_pkg::POS_W){1'b0}}, headroom})
        pos_nxt = wlsc_pkg::FULL_STROKE;
      else
        pos_nxt = pos_snap + shr.delta[wlsc_pkg::POS_W-1:0];
    end else if (dir == wlsc_pkg::DRV_IN) begin
      last_dir_nxt = dir;
      if (shr.delta >= {{(wlsc_pkg::DELTA_W-wlsc_pkg::POS_W){1'b0}}, pos_snap})
        pos_nxt = '0;
      else
        pos_nxt = pos_snap - shr.delta[wlsc_pkg::POS_W-1:0];
    end

    res.drive   = dir;
    res.pos     = pos_nxt;
    res.in_end  = pressed_nxt && (last_dir_nxt == wlsc_pkg::DRV_IN);
    res.out_end = pressed_nxt && (last_dir_nxt == wlsc_pkg::DRV_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_level_r   <= 1'b0;
      change_time_r <= '0;
      pressed_r     <= 1'b0;
      last_dir_r    <= wlsc_pkg::DRV_OFF;
      blocked_r     <= wlsc_pkg::DRV_OFF;
      pos_r         <= wlsc_pkg::HALF_STROKE;
    end else if (step_en) begin
      raw_level_r   <= raw;
      change_time_r <= change_time_nxt;
      pressed_r     <= pressed_nxt;
      last_dir_r    <= last_dir_nxt;
      blocked_r     <= blocked_nxt;
      pos_r         <= pos_nxt;
    end
  end

endmodule

>>> rtl/core/wlsc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsc_merge
// Combines the lane results into one result word and derives standby.
// ----------------------------------------------------------------------------
module wlsc_merge #(
  parameter int NUM_WINCHES = wlsc_pkg::NUM_WINCHES_DEF
) (
  input  wlsc_pkg::lane_res_t                lane_res [NUM_WINCHES],
  output logic [wlsc_pkg::OUT_TDATA_W-1:0]   tdata
);

  wlsc_pkg::drive_t           drive   [wlsc_pkg::REPORTED];
  logic [wlsc_pkg::POS_W-1:0] pos     [wlsc_pkg::REPORTED];
  logic [wlsc_pkg::REPORTED-1:0] in_end, out_end;
  logic                       standby;

  for (genvar g = 0; g < wlsc_pkg::REPORTED; g++) begin : g_rep
    if (g < NUM_WINCHES) begin : g_on
      assign drive[g]   = lane_res[g].drive;
      assign pos[g]     = lane_res[g].pos;
      assign in_end[g]  = lane_res[g].in_end;
      assign out_end[g] = lane_res[g].out_end;
    end else begin : g_off
      assign drive[g]   = wlsc_pkg::DRV_OFF;
      assign pos[g]     = '0;
      assign in_end[g]  = 1'b0;
      assign out_end[g] = 1'b0;
    end
  end

  always_comb begin
    standby = 1'b0;
    for (int i = 0; i < NUM_WINCHES; i++) begin
      standby = standby | (lane_res[i].drive != wlsc_pkg::DRV_OFF);
    end
  end

  assign tdata = {out_end, in_end, pos[2], pos[1], pos[0], standby,
                  drive[2], drive[1], drive[0]};

endmodule
